>>> rtl/lps_pkg.sv
`default_nettype none

package lps_pkg;

    // Fixed field widths of the request and result channels
    localparam int FUNC_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 5;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_READ   = 3'd1,
        FN_REMOVE = 3'd2,
        FN_FIND   = 3'd3,
        FN_CLEAR  = 3'd4
    } t_func;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INS_CHK,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_RD_ADDR,
        ST_RD_WAIT,
        ST_RM_CHK,
        ST_RM_WR,
        ST_FD_CHK,
        ST_FD_CMP,
        ST_DONE
    } t_state;

    // Pointer update
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_USED,
        PTR_POS,
        PTR_ZERO,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    // Entry count update
    typedef enum logic [1:0] {
        USED_HOLD,
        USED_INC,
        USED_DEC,
        USED_CLR
    } t_used_op;

    // Memory read address source
    typedef enum logic [1:0] {
        RA_PTR,
        RA_DEC,
        RA_INC
    } t_ra_sel;

    // Result position source
    typedef enum logic [1:0] {
        RP_NONE,
        RP_HIT,
        RP_MISS,
        RP_ONE
    } t_pos_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic     capture;
        t_ptr_op  ptr_op;
        t_used_op used_op;
        logic     mem_rd;
        t_ra_sel  ra_sel;
        logic     mem_wr;
        logic     wr_value;
        logic     res_clr;
        logic     set_ok;
        logic     ld_rd;
        t_pos_sel pos_sel;
        logic     out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_func func;
        logic  ins_ok;
        logic  acc_ok;
        logic  ptr_eq_k;
        logic  rm_end;
        logic  fd_end;
        logic  hit;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/lps_dpath.sv
`default_nettype none

module lps_dpath
    import lps_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    output logic                   o_ok,
    output logic [VAL_W-1:0]       o_read_value,
    output logic [POS_W-1:0]       o_result_position,
    output logic [CNT_W-1:0]       o_count
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((PW > POS_W) ? PW : POS_W) + 1;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [FUNC_W-1:0]     r_func;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_value;
    logic [PW-1:0]         r_ptr;
    logic [PW-1:0]         n_ptr;
    logic [PW-1:0]         r_used;
    logic [PW-1:0]         n_used;
    logic                  r_res_ok;
    logic [VAL_W-1:0]      r_res_rd;
    logic [POS_W-1:0]      r_res_pos;
    logic                  r_out_ok;
    logic [VAL_W-1:0]      r_out_rd;
    logic [POS_W-1:0]      r_out_pos;
    logic [CNT_W-1:0]      r_out_cnt;

    logic [CW-1:0]         w_pos_ext;
    logic [CW-1:0]         w_used_ext;
    logic [CW-1:0]         w_ptr_ext;
    logic [PW-1:0]         w_ra;

    assign w_pos_ext  = CW'(r_pos);
    assign w_used_ext = CW'(r_used);
    assign w_ptr_ext  = CW'(r_ptr);

    // Status toward the controller
    always_comb begin
        o_sts.func     = t_func'(r_func);
        o_sts.ins_ok   = (r_pos != '0) && (w_pos_ext <= w_used_ext + CW'(1))
                         && (r_used < PW'(DEPTH));
        o_sts.acc_ok   = (r_pos != '0) && (w_pos_ext <= w_used_ext);
        o_sts.ptr_eq_k = (w_ptr_ext + CW'(1) == w_pos_ext);
        o_sts.rm_end   = (w_ptr_ext + CW'(1) >= w_used_ext);
        o_sts.fd_end   = (w_ptr_ext >= w_used_ext);
        o_sts.hit      = (r_rdata == r_value);
    end

    // Read address
    always_comb begin
        case (i_cmd.ra_sel)
            RA_PTR:  w_ra = r_ptr;
            RA_DEC:  w_ra = r_ptr - PW'(1);
            RA_INC:  w_ra = r_ptr + PW'(1);
            default: w_ra = r_ptr;
        endcase
    end

    // Pointer and count next values
    always_comb begin
        case (i_cmd.ptr_op)
            PTR_USED: n_ptr = r_used;
            PTR_POS:  n_ptr = PW'(w_pos_ext - CW'(1));
            PTR_ZERO: n_ptr = '0;
            PTR_INC:  n_ptr = r_ptr + PW'(1);
            PTR_DEC:  n_ptr = r_ptr - PW'(1);
            default:  n_ptr = r_ptr;
        endcase
        case (i_cmd.used_op)
            USED_INC: n_used = r_used + PW'(1);
            USED_DEC: n_used = r_used - PW'(1);
            USED_CLR: n_used = '0;
            default:  n_used = r_used;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_used <= '0;
        end else begin
            r_ptr  <= n_ptr;
            r_used <= n_used;
        end
    end

    // Entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[r_ptr[AW-1:0]] <= i_cmd.wr_value ? r_value : r_rdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[w_ra[AW-1:0]];
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_pos   <= i_position;
            r_value <= DATA_WIDTH'(i_value);
        end
    end

    // Result build-up
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_ok) begin
            r_res_ok <= 1'b1;
        end else if (i_cmd.res_clr) begin
            r_res_ok <= 1'b0;
        end
        if (i_cmd.ld_rd) begin
            r_res_rd <= VAL_W'(r_rdata);
        end else if (i_cmd.res_clr) begin
            r_res_rd <= '0;
        end
        case (i_cmd.pos_sel)
            RP_HIT:  r_res_pos <= POS_W'(w_ptr_ext + CW'(1));
            RP_MISS: r_res_pos <= POS_W'(w_used_ext + CW'(1));
            RP_ONE:  r_res_pos <= POS_W'(1);
            default: begin
                if (i_cmd.res_clr) begin
                    r_res_pos <= '0;
                end
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ok  <= r_res_ok;
            r_out_rd  <= r_res_rd;
            r_out_pos <= r_res_pos;
            r_out_cnt <= CNT_W'(r_used);
        end
    end

    assign o_ok              = r_out_ok;
    assign o_read_value      = r_out_rd;
    assign o_result_position = r_out_pos;
    assign o_count           = r_out_cnt;

    // Count stays within the list depth
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= PW'(DEPTH))
        else $error("entry count above depth");

    // Growing the list only when there is room
    a_inc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.used_op == USED_INC) |-> (r_used < PW'(DEPTH)))
        else $error("insert on full list");

endmodule

`default_nettype wire

>>> rtl/lps_ctrl.sv
`default_nettype none

module lps_ctrl
    import lps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.ptr_op    = PTR_HOLD;
        o_cmd.used_op   = USED_HOLD;
        o_cmd.ra_sel    = RA_PTR;
        o_cmd.pos_sel   = RP_NONE;
        o_in_ready      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                o_cmd.res_clr = 1'b1;
                n_state       = ST_DONE;
                case (i_sts.func)
                    FN_INSERT: begin
                        if (i_sts.ins_ok) begin
                            o_cmd.set_ok = 1'b1;
                            o_cmd.ptr_op = PTR_USED;
                            n_state      = ST_INS_CHK;
                        end
                    end
                    FN_READ: begin
                        if (i_sts.acc_ok) begin
                            o_cmd.set_ok = 1'b1;
                            o_cmd.ptr_op = PTR_POS;
                            n_state      = ST_RD_ADDR;
                        end
                    end
                    FN_REMOVE: begin
                        if (i_sts.acc_ok) begin
                            o_cmd.set_ok = 1'b1;
                            o_cmd.ptr_op = PTR_POS;
                            n_state      = ST_RM_CHK;
                        end
                    end
                    FN_FIND: begin
                        o_cmd.set_ok = 1'b1;
                        o_cmd.ptr_op = PTR_ZERO;
                        n_state      = ST_FD_CHK;
                    end
                    FN_CLEAR: begin
                        o_cmd.set_ok  = 1'b1;
                        o_cmd.used_op = USED_CLR;
                        o_cmd.pos_sel = RP_ONE;
                    end
                    default: ;
                endcase
            end
            // Insert: move entries up from the tail until the gap reaches the position
            ST_INS_CHK: begin
                n_state = i_sts.ptr_eq_k ? ST_INS_PUT : ST_INS_RD;
            end
            ST_INS_RD: begin
                o_cmd.mem_rd = 1'b1;
                o_cmd.ra_sel = RA_DEC;
                n_state      = ST_INS_WR;
            end
            ST_INS_WR: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.ptr_op = PTR_DEC;
                n_state      = ST_INS_CHK;
            end
            ST_INS_PUT: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.wr_value = 1'b1;
                o_cmd.used_op  = USED_INC;
                n_state        = ST_DONE;
            end
            // Read: one memory access
            ST_RD_ADDR: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                o_cmd.ld_rd = 1'b1;
                n_state     = ST_DONE;
            end
            // Remove: move later entries down one slot at a time
            ST_RM_CHK: begin
                if (i_sts.rm_end) begin
                    o_cmd.used_op = USED_DEC;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.ra_sel = RA_INC;
                    n_state      = ST_RM_WR;
                end
            end
            ST_RM_WR: begin
                o_cmd.mem_wr = 1'b1;
                o_cmd.ptr_op = PTR_INC;
                n_state      = ST_RM_CHK;
            end
            // Find: linear scan from the head
            ST_FD_CHK: begin
                if (i_sts.fd_end) begin
                    o_cmd.pos_sel = RP_MISS;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = ST_FD_CMP;
                end
            end
            ST_FD_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.pos_sel = RP_HIT;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                    n_state      = ST_FD_CHK;
                end
            end
            // Hand the result over once the output register is free
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    // One request at a time
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while busy");

    // Output register is never overwritten while holding an untaken result
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");

    // A finished result waits while the receiver stalls
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_out_ready) |=> (r_state == ST_DONE))
        else $error("result lost under stall");

endmodule

`default_nettype wire

>>> rtl/positional_list_store.sv
// Positional list store: an ordered list of up to DEPTH words kept packed from position 1.
// Request channel (i_in_valid / o_in_ready) carries func, position and value; result
// channel (o_out_valid / i_out_ready) returns ok, read_value, result_position and count.
// One request is worked on at a time; entries live in one memory that the sequencer
// accesses one entry at a time, so each moved or scanned entry takes its own access.
// Insert moves (count - position + 1) entries up, remove moves (count - position)
// entries down, and find scans from the head up to the hit position, or over all
// count entries on a miss; clear, read and refused requests move no entries.
// A new request is taken the cycle after the result is loaded into the output register,
// so the next request proceeds while the previous result waits for the receiver.
// If the receiver stalls, a finished result waits in the result registers until the
// output register frees up. Reset empties the list (count 0) and drops any pending
// result; the entry memory is not cleared and is never read beyond the held count.
`default_nettype none

module positional_list_store
    import lps_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic [VAL_W-1:0]  i_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_ok,
    output logic [VAL_W-1:0]       o_read_value,
    output logic [POS_W-1:0]       o_result_position,
    output logic [CNT_W-1:0]       o_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    lps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Entry memory, pointer, count and result registers
    lps_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_func            (i_func),
        .i_position        (i_position),
        .i_value           (i_value),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_ok              (o_ok),
        .o_read_value      (o_read_value),
        .o_result_position (o_result_position),
        .o_count           (o_count)
    );

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench
    import lps_pkg::*;
();

    localparam int LIST_DEPTH      = 16;
    localparam int DIRECTED_ROWS   = 26;
    localparam int RANDOM_BLOCKS   = 11;
    localparam int BLOCK_ITEMS     = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    // slowest request is an insert at the head of 15 entries
    localparam int DRAIN_CYCLES    = 80;
    // allows for the receiver hold-off plus the slowest request many times over
    localparam int WATCHDOG_LIMIT  = 4000;

    // function codes that select no operation
    localparam logic [FUNC_W-1:0] FN_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

    // bias of the random requests
    typedef enum int {
        MIX_BALANCED,
        MIX_GROW,
        MIX_SHRINK
    } t_mix;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] read_value;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
        logic              fixed;   // expectation typed in below
        t_result           want;
    } t_request;

    localparam t_result NO_RESULT = '0;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic [FUNC_W-1:0] i_func      = '0;
    logic [POS_W-1:0]  i_position  = '0;
    logic [VAL_W-1:0]  i_value     = '0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_ok;
    logic [VAL_W-1:0]  o_read_value;
    logic [POS_W-1:0]  o_result_position;
    logic [CNT_W-1:0]  o_count;

    // typed expectation travelling with the request on the bus
    logic    drv_fixed = 1'b0;
    t_result drv_want  = '0;

    // shadow of the list
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_used = 0;

    t_result  pending_results [$];
    int       errors       = 0;
    int       idle_cycles  = 0;
    bit       quiet_run    = 1'b0;
    bit       hold_off_req = 1'b0;
    t_request dir_rows [DIRECTED_ROWS];

    positional_list_store #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (VAL_W)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_position        (i_position),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_ok              (o_ok),
        .o_read_value      (o_read_value),
        .o_result_position (o_result_position),
        .o_count           (o_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // apply one request to the shadow list and return what the block should answer
    function automatic t_result list_apply(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                           logic [VAL_W-1:0] val);
        t_result res;
        int      p;
        res = NO_RESULT;
        p = int'(pos);
        case (func)
            FN_INSERT: begin
                if (p >= 1 && p <= list_used + 1 && list_used < LIST_DEPTH) begin
                    for (int i = list_used; i >= p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = val;
                    list_used++;
                    res.ok = 1'b1;
                end
            end
            FN_READ: begin
                if (p >= 1 && p <= list_used) begin
                    res.read_value = list_mem[p-1];
                    res.ok = 1'b1;
                end
            end
            FN_REMOVE: begin
                if (p >= 1 && p <= list_used) begin
                    for (int i = p - 1; i + 1 < list_used; i++)
                        list_mem[i] = list_mem[i+1];
                    list_used--;
                    res.ok = 1'b1;
                end
            end
            FN_FIND: begin
                // lowest matching position, or one past the end
                res.position = POS_W'(list_used + 1);
                for (int i = list_used - 1; i >= 0; i--)
                    if (list_mem[i] == val)
                        res.position = POS_W'(i + 1);
                res.ok = 1'b1;
            end
            FN_CLEAR: begin
                list_used = 0;
                res.position = 1;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.count = CNT_W'(list_used);
        return res;
    endfunction

    // random request, mostly in range for the current list
    function automatic t_request pick_request(t_mix mix);
        t_request req;
        int       held;
        int       ins_w;
        int       rm_w;
        int       roll;
        held  = list_used;
        ins_w = (mix == MIX_GROW) ? 60 : (mix == MIX_SHRINK) ? 15 : 35;
        rm_w  = (mix == MIX_SHRINK) ? 40 : 15;
        req   = '0;
        roll  = $urandom_range(ins_w + rm_w + 34);
        if (roll < ins_w)
            req.func = FN_INSERT;
        else if (roll < ins_w + rm_w)
            req.func = FN_REMOVE;
        else if (roll < ins_w + rm_w + 15)
            req.func = FN_READ;
        else if (roll < ins_w + rm_w + 30)
            req.func = FN_FIND;
        else if (roll < ins_w + rm_w + 32)
            req.func = FN_CLEAR;
        else
            req.func = FN_RSVD5 + FUNC_W'($urandom_range(2));

        // position: in range most of the time
        if ($urandom_range(99) < 15 || req.func == FN_FIND || req.func == FN_CLEAR)
            req.position = POS_W'($urandom_range(31));
        else if (req.func == FN_INSERT)
            req.position = POS_W'($urandom_range(held + 1, 1));
        else
            req.position = POS_W'($urandom_range(held > 0 ? held : 1, 1));

        // value: small pool for duplicates, extremes, held entries for find hits
        roll = $urandom_range(99);
        if (req.func == FN_FIND && held > 0 && roll < 40)
            req.value = list_mem[$urandom_range(held - 1)];
        else if (roll < 70)
            req.value = $urandom();
        else if (roll < 90)
            req.value = VAL_W'($urandom_range(7));
        else
            req.value = $urandom_range(1) ? '1 : '0;
        return req;
    endfunction

    // offer one request, idling first at random, and wait until it is taken
    task automatic send_request(input t_request req);
        while (!quiet_run && $urandom_range(99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= req.func;
        i_position <= req.position;
        i_value    <= req.value;
        drv_fixed  <= req.fixed;
        drv_want   <= req.want;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // result receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            i_out_ready <= quiet_run || ($urandom_range(99) >= 22);
        end
    end

    // check results, predict accepted requests, watchdog
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_ok, o_read_value, o_result_position, o_count};
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected: %h", $time, got);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok) begin
                        $display("%0t: ok expected %h got %h", $time, want.ok, got.ok);
                        errors++;
                    end
                    if (got.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %h got %h", $time,
                                 want.read_value, got.read_value);
                        errors++;
                    end
                    if (got.position !== want.position) begin
                        $display("%0t: result_position expected %0d got %0d", $time,
                                 want.position, got.position);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: count expected %0d got %0d", $time,
                                 want.count, got.count);
                        errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = list_apply(i_func, i_position, i_value);
                pending_results.push_back(drv_fixed ? drv_want : want);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAIL positional_list_store");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_request req;
        dir_rows = '{
            // empty list: everything positional is refused, find gives 1
            '{FN_READ,   5'd1,  32'h0,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd0}},
            '{FN_REMOVE, 5'd1,  32'h0,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd0}},
            '{FN_FIND,   5'd0,  32'h0,        1'b1, '{1'b1, 32'h0,        5'd1, 5'd0}},
            '{FN_INSERT, 5'd0,  32'h5,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd0}},
            '{FN_INSERT, 5'd2,  32'h5,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd0}},
            // build [0, ffffffff]
            '{FN_INSERT, 5'd1,  32'hffffffff, 1'b1, '{1'b1, 32'h0,        5'd0, 5'd1}},
            '{FN_INSERT, 5'd1,  32'h0,        1'b1, '{1'b1, 32'h0,        5'd0, 5'd2}},
            '{FN_READ,   5'd2,  32'h0,        1'b1, '{1'b1, 32'hffffffff, 5'd0, 5'd2}},
            '{FN_READ,   5'd1,  32'h0,        1'b1, '{1'b1, 32'h0,        5'd0, 5'd2}},
            '{FN_READ,   5'd3,  32'h0,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd2}},
            '{FN_READ,   5'd31, 32'hffffffff, 1'b1, '{1'b0, 32'h0,        5'd0, 5'd2}},
            '{FN_FIND,   5'd0,  32'hffffffff, 1'b1, '{1'b1, 32'h0,        5'd2, 5'd2}},
            '{FN_FIND,   5'd0,  32'h12345678, 1'b1, '{1'b1, 32'h0,        5'd3, 5'd2}},
            // append, insert in the middle, duplicate value
            '{FN_INSERT, 5'd3,  32'ha5a5a5a5, 1'b0, NO_RESULT},
            '{FN_INSERT, 5'd2,  32'h5a5a5a5a, 1'b0, NO_RESULT},
            '{FN_INSERT, 5'd31, 32'h1,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd4}},
            '{FN_INSERT, 5'd2,  32'h0,        1'b0, NO_RESULT},
            '{FN_FIND,   5'd31, 32'h0,        1'b0, NO_RESULT},
            // remove head, past the end, tail
            '{FN_REMOVE, 5'd1,  32'h0,        1'b0, NO_RESULT},
            '{FN_REMOVE, 5'd5,  32'h0,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd4}},
            '{FN_REMOVE, 5'd4,  32'h0,        1'b0, NO_RESULT},
            // unused codes change nothing
            '{FN_RSVD5,  5'd1,  32'h0,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd3}},
            '{FN_RSVD6,  5'd16, 32'h1,        1'b1, '{1'b0, 32'h0,        5'd0, 5'd3}},
            '{FN_RSVD7,  5'd31, 32'hffffffff, 1'b1, '{1'b0, 32'h0,        5'd0, 5'd3}},
            '{FN_CLEAR,  5'd0,  32'h0,        1'b1, '{1'b1, 32'h0,        5'd1, 5'd0}},
            '{FN_FIND,   5'd0,  32'hffffffff, 1'b1, '{1'b1, 32'h0,        5'd1, 5'd0}}
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_request(dir_rows[k]);

        // random blocks cycle through grow, shrink and balanced
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            quiet_run = (blk == 4);
            if (blk == 2)
                hold_off_req = 1'b1;
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                req = pick_request(t_mix'((blk + 1) % 3));
                send_request(req);
            end
        end
        quiet_run = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS positional_list_store");
        else
            $display("FAIL positional_list_store");
        $finish;
    end

endmodule
